FILE: rtl/core/xtes_pkg.sv
package xtes_pkg;

	// Longest escape sequence: "&#1114111;".
	localparam int MAX_BYTES  = 10;
	localparam int LEN_W      = 4;
	localparam int NUM_DIGITS = 7;
	localparam int CP_W       = 21;

	// Reciprocal of ten, exact for every value below 2**22.
	localparam logic [19:0] DIV10_MUL   = 20'd838861;
	localparam int          DIV10_SHIFT = 23;

	localparam logic [CP_W-1:0] SUPP_LO = 21'h010000;
	localparam logic [CP_W-1:0] SUPP_HI = 21'h10FFFF;
	localparam logic [CP_W-1:0] DEC_5   = 21'd100000;
	localparam logic [CP_W-1:0] DEC_6   = 21'd1000000;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_DEC  = 3'd1,
		KIND_HEX  = 3'd2,
		KIND_LT   = 3'd3,
		KIND_GT   = 3'd4,
		KIND_AMP  = 3'd5,
		KIND_QUOT = 3'd6,
		KIND_UTF8 = 3'd7
	} kind_t;

	typedef struct packed {
		kind_t                       kind;
		logic [CP_W-1:0]             cp;
		logic [CP_W-1:0]             quo;
		logic [4*NUM_DIGITS-1:0]     digits;
	} pipe_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = 8'h30 + {4'b0, d};
		end else begin
			r = 8'h37 + {4'b0, d};
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/xtes_digit_stage.sv
module xtes_digit_stage
	import xtes_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  pipe_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output pipe_t out_data
);

	logic            valid_s1;
	pipe_t           data_s1;
	logic [40:0]     prod;
	logic [CP_W-1:0] quo_next;
	logic [CP_W-1:0] quo_x10;
	logic [CP_W-1:0] rem;

	// One decimal digit per stage: quotient by reciprocal, remainder by shift-add.
	assign prod     = {20'b0, in_data.quo} * {21'b0, DIV10_MUL};
	assign quo_next = {3'b0, prod[40:DIV10_SHIFT]};
	assign quo_x10  = (quo_next << 3) + (quo_next << 1);
	assign rem      = in_data.quo - quo_x10;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Digits shift in from the top, so the least significant ends in the low nibble.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.kind   <= in_data.kind;
			data_s1.cp     <= in_data.cp;
			data_s1.quo    <= quo_next;
			data_s1.digits <= {rem[3:0], in_data.digits[4*NUM_DIGITS-1:4]};
		end
	end

endmodule

FILE: rtl/core/xml_text_escape_serializer.sv
// Channel  Dir  tdata                      tuser        tlast
// s_*      in   [20:0] scalar              [0] mode     -
// m_*      out  [7:0] out_byte             -            last_byte
//
// A request runs through nine register stages: an input stage that classifies
// the code point, seven stages that each strip one decimal digit, and a byte
// buffer that sends one byte a cycle while m_tready is high. One code point is
// taken per cycle while the output keeps up; a multi-byte code point holds the
// buffer until its last byte is accepted, so the sustained rate is set by the
// single output byte port. Code point zero is dropped at the buffer.
// Reset clears all valid bits and the buffer count; no payload is cleared.
// A stall on m_tready backs up stage by stage, nothing is lost or repeated.
module xml_text_escape_serializer
	import xtes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [20:0] scalar, [23:21] zero
	input  logic        s_tuser,   // [0] mode: 0 text node, 1 attribute value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast    // last byte of this code point
);

	logic            valid_s1;
	pipe_t           data_s1;
	logic [CP_W-1:0] in_cp;
	logic            in_mode;
	kind_t           in_kind;
	logic            is_ctrl;

	logic [NUM_DIGITS:0] stg_valid;
	logic [NUM_DIGITS:0] stg_ready;
	pipe_t               stg_data [NUM_DIGITS+1];

	logic [7:0]       byte_q [MAX_BYTES];
	logic [LEN_W-1:0] len_q;
	logic [7:0]       nb [MAX_BYTES];
	logic [LEN_W-1:0] nlen;
	logic             pop;
	logic             free;
	logic             take;

	assign in_cp   = s_tdata[CP_W-1:0];
	assign in_mode = s_tuser;

	// Classify on entry so that the later stages only carry a kind code.
	assign is_ctrl = ((in_cp >= 21'h01) && (in_cp <= 21'h1F))
		|| ((in_cp >= 21'h7F) && (in_cp <= 21'h9F));

	always_comb begin
		in_kind = KIND_UTF8;
		if (in_cp == '0) begin
			in_kind = KIND_NONE;
		end else if ((in_cp >= SUPP_LO) && (in_cp <= SUPP_HI)) begin
			in_kind = KIND_DEC;
		end else if (is_ctrl) begin
			// Tab and line feed pass raw inside a text node.
			if (!in_mode && ((in_cp == 21'h0A) || (in_cp == 21'h09))) begin
				in_kind = KIND_UTF8;
			end else begin
				in_kind = KIND_HEX;
			end
		end else if (in_cp == 21'h3C) begin
			in_kind = KIND_LT;
		end else if (in_cp == 21'h3E) begin
			in_kind = KIND_GT;
		end else if (in_cp == 21'h26) begin
			in_kind = KIND_AMP;
		end else if ((in_cp == 21'h22) && in_mode) begin
			in_kind = KIND_QUOT;
		end
	end

	assign s_tready = !valid_s1 || stg_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1.kind   <= in_kind;
			data_s1.cp     <= in_cp;
			data_s1.quo    <= in_cp;
			data_s1.digits <= '0;
		end
	end

	assign stg_valid[0] = valid_s1;
	assign stg_data[0]  = data_s1;

	// Decimal conversion, one digit per stage.
	for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
		xtes_digit_stage u_digit (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[k]),
			.in_ready  (stg_ready[k]),
			.in_data   (stg_data[k]),
			.out_valid (stg_valid[k+1]),
			.out_ready (stg_ready[k+1]),
			.out_data  (stg_data[k+1])
		);
	end

	// Build the byte sequence from the last stage; first byte lands in slot 0.
	always_comb begin
		pipe_t      p;
		logic [7:0] asc [NUM_DIGITS];
		p = stg_data[NUM_DIGITS];
		for (int i = 0; i < MAX_BYTES; i++) begin
			nb[i] = 8'h00;
		end
		for (int i = 0; i < NUM_DIGITS; i++) begin
			asc[i] = 8'h30 | {4'b0, p.digits[4*i +: 4]};
		end
		nlen = '0;
		case (p.kind)
			KIND_DEC: begin
				nb[0] = "&";
				nb[1] = "#";
				if (p.cp < DEC_5) begin
					nb[2] = asc[4];
					nb[3] = asc[3];
					nb[4] = asc[2];
					nb[5] = asc[1];
					nb[6] = asc[0];
					nb[7] = ";";
					nlen  = 4'd8;
				end else if (p.cp < DEC_6) begin
					nb[2] = asc[5];
					nb[3] = asc[4];
					nb[4] = asc[3];
					nb[5] = asc[2];
					nb[6] = asc[1];
					nb[7] = asc[0];
					nb[8] = ";";
					nlen  = 4'd9;
				end else begin
					nb[2] = asc[6];
					nb[3] = asc[5];
					nb[4] = asc[4];
					nb[5] = asc[3];
					nb[6] = asc[2];
					nb[7] = asc[1];
					nb[8] = asc[0];
					nb[9] = ";";
					nlen  = 4'd10;
				end
			end
			KIND_HEX: begin
				nb[0] = "&";
				nb[1] = "#";
				nb[2] = "x";
				if (p.cp[7:4] != 4'h0) begin
					nb[3] = hex_char(p.cp[7:4]);
					nb[4] = hex_char(p.cp[3:0]);
					nb[5] = ";";
					nlen  = 4'd6;
				end else begin
					nb[3] = hex_char(p.cp[3:0]);
					nb[4] = ";";
					nlen  = 4'd5;
				end
			end
			KIND_LT: begin
				nb[0] = "&";
				nb[1] = "l";
				nb[2] = "t";
				nb[3] = ";";
				nlen  = 4'd4;
			end
			KIND_GT: begin
				nb[0] = "&";
				nb[1] = "g";
				nb[2] = "t";
				nb[3] = ";";
				nlen  = 4'd4;
			end
			KIND_AMP: begin
				nb[0] = "&";
				nb[1] = "a";
				nb[2] = "m";
				nb[3] = "p";
				nb[4] = ";";
				nlen  = 4'd5;
			end
			KIND_QUOT: begin
				nb[0] = "&";
				nb[1] = "q";
				nb[2] = "u";
				nb[3] = "o";
				nb[4] = "t";
				nb[5] = ";";
				nlen  = 4'd6;
			end
			KIND_UTF8: begin
				// Values above the Unicode range still take the four-byte form.
				if (p.cp < 21'h80) begin
					nb[0] = p.cp[7:0];
					nlen  = 4'd1;
				end else if (p.cp < 21'h800) begin
					nb[0] = {3'b110, p.cp[10:6]};
					nb[1] = {2'b10, p.cp[5:0]};
					nlen  = 4'd2;
				end else if (p.cp < 21'h10000) begin
					nb[0] = {4'b1110, p.cp[15:12]};
					nb[1] = {2'b10, p.cp[11:6]};
					nb[2] = {2'b10, p.cp[5:0]};
					nlen  = 4'd3;
				end else begin
					nb[0] = {5'b11110, p.cp[20:18]};
					nb[1] = {2'b10, p.cp[17:12]};
					nb[2] = {2'b10, p.cp[11:6]};
					nb[3] = {2'b10, p.cp[5:0]};
					nlen  = 4'd4;
				end
			end
			default: begin
				nlen = '0;
			end
		endcase
	end

	// Output buffer: shifts down one byte per accepted transfer. A request
	// with no bytes is taken and leaves the buffer empty.
	assign m_tvalid = (len_q != '0);
	assign m_tdata  = byte_q[0];
	assign m_tlast  = (len_q == 4'd1);
	assign pop      = m_tvalid && m_tready;
	assign free     = !m_tvalid || (pop && m_tlast);
	assign take     = stg_valid[NUM_DIGITS] && free;

	assign stg_ready[NUM_DIGITS] = free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (take) begin
			len_q <= nlen;
		end else if (pop) begin
			len_q <= len_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < MAX_BYTES; i++) begin
				byte_q[i] <= nb[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_BYTES - 1; i++) begin
				byte_q[i] <= byte_q[i+1];
			end
			byte_q[MAX_BYTES-1] <= 8'h00;
		end
	end

	// The buffer never holds more than the longest sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= 4'(MAX_BYTES))
		else $error("byte buffer count out of range");

	// No produced byte is ever NUL, since code point zero is dropped.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata != 8'h00))
		else $error("NUL byte on output");

	// Input backpressure only arises when every stage is occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&stg_valid))
		else $error("input stalled with a free stage");

	// After the last byte goes out with nothing new loaded, the output is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && m_tlast && !take) |=> !m_tvalid)
		else $error("output valid after final byte");

endmodule

FILE: tb/xtes_escape_monitor.sv
`timescale 1ns / 100ps

// Watches both stream channels. It turns each accepted code point into the bytes
// the escaper should send and compares every sent byte against them in order.
module xtes_escape_monitor
	import xtes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // [20:0] scalar, [23:21] zero
	input  logic        s_tuser,   // [0] mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [7:0] out_byte
	input  logic        m_tlast,   // last byte of this code point
	output int          mismatches,
	output int          pending_bytes,
	output int          bytes_checked
);

	localparam logic [CP_W-1:0] CP_TAB   = 21'h09;
	localparam logic [CP_W-1:0] CP_LF    = 21'h0A;
	localparam logic [CP_W-1:0] CP_QUOTE = 21'h22;
	localparam logic [CP_W-1:0] CP_AMP   = 21'h26;
	localparam logic [CP_W-1:0] CP_LT    = 21'h3C;
	localparam logic [CP_W-1:0] CP_GT    = 21'h3E;
	localparam logic [CP_W-1:0] C0_FIRST = 21'h01;
	localparam logic [CP_W-1:0] C0_LAST  = 21'h1F;
	localparam logic [CP_W-1:0] C1_FIRST = 21'h7F;
	localparam logic [CP_W-1:0] C1_LAST  = 21'h9F;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} escaped_byte_t;

	escaped_byte_t expected_bytes [$];
	int mismatch_count = 0;
	int pending_count  = 0;
	int checked_count  = 0;

	assign mismatches    = mismatch_count;
	assign pending_bytes = pending_count;
	assign bytes_checked = checked_count;

	function automatic kind_t classify_scalar(input logic [CP_W-1:0] cp, input logic attr);
		kind_t kind;
		if (cp == '0) begin
			kind = KIND_NONE;
		end else if (cp >= SUPP_LO && cp <= SUPP_HI) begin
			kind = KIND_DEC;
		end else if ((cp >= C0_FIRST && cp <= C0_LAST) || (cp >= C1_FIRST && cp <= C1_LAST)) begin
			// Tab and line feed survive raw inside a text node.
			kind = (!attr && (cp == CP_TAB || cp == CP_LF)) ? KIND_UTF8 : KIND_HEX;
		end else if (cp == CP_LT) begin
			kind = KIND_LT;
		end else if (cp == CP_GT) begin
			kind = KIND_GT;
		end else if (cp == CP_AMP) begin
			kind = KIND_AMP;
		end else if (cp == CP_QUOTE && attr) begin
			kind = KIND_QUOT;
		end else begin
			kind = KIND_UTF8;
		end
		return kind;
	endfunction

	function automatic logic [7:0] hex_ascii(input logic [3:0] nibble);
		return (nibble < 4'd10) ? 8'h30 + 8'(nibble) : 8'h41 + 8'(nibble) - 8'd10;
	endfunction

	// Appends the byte sequence of one code point to the expected stream.
	function automatic void escape_to_bytes(input logic [CP_W-1:0] cp, input logic attr);
		kind_t         kind;
		logic [7:0]    seq [$];
		logic [7:0]    digits [$];
		int unsigned   v;
		string         entity;
		escaped_byte_t e;
		kind = classify_scalar(cp, attr);
		entity = "";
		case (kind)
			KIND_DEC: begin
				seq.push_back("&");
				seq.push_back("#");
				v = 32'(cp);
				do begin
					digits.push_front(8'h30 + 8'(v % 10));
					v = v / 10;
				end while (v != 0);
				while (digits.size() != 0) seq.push_back(digits.pop_front());
				seq.push_back(";");
			end
			KIND_HEX: begin
				seq.push_back("&");
				seq.push_back("#");
				seq.push_back("x");
				// Controls stop at 0x9F, so two digits at most, leading zero dropped.
				if (cp[7:4] != 4'd0) seq.push_back(hex_ascii(cp[7:4]));
				seq.push_back(hex_ascii(cp[3:0]));
				seq.push_back(";");
			end
			KIND_LT:   entity = "&lt;";
			KIND_GT:   entity = "&gt;";
			KIND_AMP:  entity = "&amp;";
			KIND_QUOT: entity = "&quot;";
			KIND_UTF8: begin
				if (cp < 21'h80) begin
					seq.push_back(cp[7:0]);
				end else if (cp < 21'h800) begin
					seq.push_back({3'b110, cp[10:6]});
					seq.push_back({2'b10, cp[5:0]});
				end else if (cp < 21'h10000) begin
					seq.push_back({4'b1110, cp[15:12]});
					seq.push_back({2'b10, cp[11:6]});
					seq.push_back({2'b10, cp[5:0]});
				end else begin
					// Only code points above the Unicode range get here.
					seq.push_back({5'b11110, cp[20:18]});
					seq.push_back({2'b10, cp[17:12]});
					seq.push_back({2'b10, cp[11:6]});
					seq.push_back({2'b10, cp[5:0]});
				end
			end
			default: ;
		endcase
		for (int i = 0; i < entity.len(); i++) seq.push_back(entity[i]);
		for (int i = 0; i < seq.size(); i++) begin
			e.value = seq[i];
			e.last  = (i == seq.size() - 1);
			expected_bytes.push_back(e);
		end
	endfunction

	always @(posedge clk) begin : watch
		escaped_byte_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) escape_to_bytes(s_tdata[CP_W-1:0], s_tuser);
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					mismatch_count++;
					$display("%0t: byte 0x%02h last=%0b sent with nothing expected",
						$time, m_tdata, m_tlast);
				end else begin
					want = expected_bytes.pop_front();
					checked_count++;
					if (want.value !== m_tdata) begin
						mismatch_count++;
						$display("%0t: out_byte expected 0x%02h, actual 0x%02h",
							$time, want.value, m_tdata);
					end
					if (want.last !== m_tlast) begin
						mismatch_count++;
						$display("%0t: last_byte expected %0b, actual %0b",
							$time, want.last, m_tlast);
					end
				end
			end
		end
		pending_count = expected_bytes.size();
	end

endmodule

FILE: tb/tb_xml_text_escape_serializer.sv
`timescale 1ns / 100ps

// Top of the escaper bench. It drives code point requests, runs the byte
// receiver with its random stalls, and gives the verdict. All prediction and
// comparison is done by the monitor beside the block.
module tb_xml_text_escape_serializer;
	import xtes_pkg::*;

	localparam int RANDOM_REQUESTS  = 220;
	localparam int LONG_HOLD_CYCLES = 200;
	// Nine register stages plus up to ten bytes in the output buffer.
	localparam int DRAIN_CYCLES     = 40;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;    // [20:0] scalar, [23:21] zero
	logic        s_tuser;    // [0] mode: 0 text node, 1 attribute value
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;    // [7:0] out_byte
	logic        m_tlast;    // last byte of this code point

	int mismatches;
	int pending_bytes;
	int bytes_checked;
	int requests_sent = 0;

	// Sender gaps are decided in the stimulus process alone; receiver stalls
	// and the long hold-off are requested through rx_idle_en and holds_wanted,
	// written with nonblocking assignments so the receiver sees them cleanly at the edge.
	bit tx_idle_en   = 1'b0;
	bit rx_idle_en   = 1'b0;
	int holds_wanted = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	xml_text_escape_serializer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	xtes_escape_monitor u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.mismatches    (mismatches),
		.pending_bytes (pending_bytes),
		.bytes_checked (bytes_checked)
	);

	// Edge cases first, packed as {mode, scalar}. They cover the end of
	// string marker, the shortest and longest hex references, tab and line
	// feed in both modes, the double quote in both modes, the three named
	// entities, each UTF-8 length boundary, both ends of the surrogate block,
	// both ends of the supplementary range and code points above Unicode.
	logic [21:0] directed_requests [25] = '{
		{1'b0, 21'h000000}, {1'b0, 21'h000001}, {1'b0, 21'h000009}, {1'b1, 21'h000009},
		{1'b0, 21'h00000A}, {1'b1, 21'h00000A}, {1'b1, 21'h00001F}, {1'b0, 21'h000020},
		{1'b0, 21'h000022}, {1'b1, 21'h000022}, {1'b1, 21'h00003C}, {1'b0, 21'h00003E},
		{1'b0, 21'h000026}, {1'b0, 21'h00007F}, {1'b1, 21'h00009F}, {1'b0, 21'h0000A0},
		{1'b0, 21'h0007FF}, {1'b1, 21'h000800}, {1'b0, 21'h00D800}, {1'b1, 21'h00DFFF},
		{1'b0, 21'h00FFFF}, {1'b1, 21'h010000}, {1'b0, 21'h10FFFF}, {1'b0, 21'h110000},
		{1'b1, 21'h1FFFFF}
	};

	// Offers one request and holds it until the block takes it. After the
	// handshake the sender may drop valid for a random burst of idle cycles.
	task automatic send_scalar(input logic [20:0] cp, input logic attr);
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, cp};
		s_tuser  <= attr;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests_sent++;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Random code points, weighted so that every escaping path gets plenty of
	// traffic. Supplementary code points give the long decimal references
	// that keep the output busy longest, up to ten bytes.
	function automatic logic [20:0] pick_scalar();
		int          sel;
		logic [20:0] cp;
		sel = $urandom_range(0, 99);
		if (sel < 4) begin
			cp = '0;
		end else if (sel < 16) begin
			cp = ($urandom_range(0, 1) == 0) ? 21'($urandom_range(1, 31))
				: 21'($urandom_range(127, 159));
		end else if (sel < 26) begin
			case ($urandom_range(0, 5))
				0:       cp = 21'h09;
				1:       cp = 21'h0A;
				2:       cp = 21'h22;
				3:       cp = 21'h26;
				4:       cp = 21'h3C;
				default: cp = 21'h3E;
			endcase
		end else if (sel < 46) begin
			cp = 21'($urandom_range(32, 126));
		end else if (sel < 56) begin
			cp = 21'($urandom_range(128, 2047));
		end else if (sel < 68) begin
			cp = 21'($urandom_range(2048, 65535));
		end else if (sel < 72) begin
			cp = 21'($urandom_range(21'h00D800, 21'h00DFFF));
		end else if (sel < 92) begin
			cp = 21'($urandom_range(21'h010000, 21'h10FFFF));
		end else begin
			cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
		end
		return cp;
	endfunction

	// Byte receiver. It normally accepts every cycle, stalls in random bursts
	// while stalls are enabled, and once goes quiet for a long stretch so the
	// pipeline fills and pushes back on the sender.
	initial begin : receiver
		int holds_done;
		holds_done = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_done < holds_wanted) begin
				holds_done++;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge cases go through with gaps and stalls already active.
		tx_idle_en = 1'b1;
		rx_idle_en <= 1'b1;
		foreach (directed_requests[i])
			send_scalar(directed_requests[i][20:0], directed_requests[i][21]);

		// Random part in phases: idling on both sides, a stretch with none,
		// idling again with one long receiver hold-off, and a final run at
		// full rate.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == 60) begin
				tx_idle_en = 1'b0;
				rx_idle_en <= 1'b0;
			end else if (i == 100) begin
				tx_idle_en = 1'b1;
				rx_idle_en <= 1'b1;
				holds_wanted <= 1;
			end else if (i == 180) begin
				tx_idle_en = 1'b0;
				rx_idle_en <= 1'b0;
			end
			send_scalar(pick_scalar(), 1'($urandom_range(0, 1)));
		end
		s_tvalid <= 1'b0;

		// Wait for every expected byte, then give the block time to show any
		// stray output.
		@(negedge clk);
		while (pending_bytes != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);

		$display("Sent %0d code point requests (edge cases, controls, entities, every UTF-8",
			requests_sent);
		$display("length, decimal references, end of string) and checked %0d output bytes.",
			bytes_checked);
		if (mismatches == 0 && pending_bytes == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run with every stall at its
	// longest and the long hold-off included.
	initial begin : watchdog
		#5_000_000;
		$display("Timed out with %0d bytes still expected.", pending_bytes);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/xtes_pkg.sv
rtl/core/xtes_digit_stage.sv
rtl/core/xml_text_escape_serializer.sv
tb/xtes_escape_monitor.sv
tb/tb_xml_text_escape_serializer.sv
